// File: rtl/iwo_pkg.sv
// Shared types and constants for the interpolating wavetable oscillator.
// Holds the queue item format, the back-end sequencer states and the mode codes.
// No dependencies; every other file but iwo_ram refers to it by scoped names.
package iwo_pkg;

    // Table and phase geometry
    localparam int ADDR_W      = 10;
    localparam int TABLE_LEN   = 1 << ADDR_W;
    localparam int FRAC_BITS   = 16;
    localparam int PHASE_W     = ADDR_W + FRAC_BITS;
    localparam int STEP_W      = 27;
    localparam int VAL_W       = 16;
    localparam int AMP_W       = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int MODE_W      = 2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Interpolation mode codes; the remaining code behaves as cubic.
    localparam logic [MODE_W-1:0] MODE_TRUNC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CUBIC  = 2'd2;

    // Opcode of an input beat
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes
    localparam logic REG_INTERP_MODE  = 1'b0;
    localparam logic REG_PHASE_OFFSET = 1'b1;

    // One classified item as it travels through the queue.
    // For a tick, addr carries the integer table index and frac the phase fraction.
    typedef struct packed {
        logic                    is_tick;
        logic [ADDR_W-1:0]       addr;
        logic signed [VAL_W-1:0] value;
        logic [FRAC_BITS-1:0]    frac;
        logic signed [AMP_W-1:0] amp;
    } t_item;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_COEF,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_A1,
        ST_A2,
        ST_SUM,
        ST_DIV,
        ST_FIN
    } t_back_state;

endpackage

// File: rtl/iwo_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the wave table; no dependencies.
module iwo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/iwo_fifo.sv
// Short queue of classified items between the front and back parts.
// Depends on iwo_pkg for the item type and the queue depth.
module iwo_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  iwo_pkg::t_item i_item,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output iwo_pkg::t_item o_item
);

    iwo_pkg::t_item                  r_mem [iwo_pkg::QUEUE_DEPTH];
    logic [iwo_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [iwo_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [iwo_pkg::QCNT_W-1:0]      r_count;

    // Storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == iwo_pkg::QPTR_W'(iwo_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == iwo_pkg::QPTR_W'(iwo_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == iwo_pkg::QCNT_W'(iwo_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

endmodule

// File: rtl/iwo_front.sv
// Front part: accepts input beats, classifies them as loads or ticks,
// owns the phase accumulator and pushes classified items into the queue.
// Depends on iwo_pkg.
module iwo_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_op,
    input  logic [iwo_pkg::ADDR_W-1:0]          i_table_addr,
    input  logic signed [iwo_pkg::VAL_W-1:0]    i_table_value,
    input  logic signed [iwo_pkg::STEP_W-1:0]   i_phase_step,
    input  logic signed [iwo_pkg::AMP_W-1:0]    i_amplitude,
    input  logic [iwo_pkg::ADDR_W-1:0]          i_phase_offset,
    input  logic                                i_full,
    output logic                                o_push,
    output iwo_pkg::t_item                      o_item
);

    logic [iwo_pkg::PHASE_W-1:0] r_phase;
    logic [iwo_pkg::PHASE_W-1:0] read_pos;
    logic                        accept;
    logic                        is_tick;

    assign accept     = i_in_valid && !i_full;
    assign o_in_stall = i_full;
    assign o_push     = accept;
    assign is_tick    = (i_op == iwo_pkg::OP_TICK);

    // Read position is the phase plus the offset in whole entries, wrapping.
    assign read_pos = r_phase + {i_phase_offset, {iwo_pkg::FRAC_BITS{1'b0}}};

    // Classify the beat; a tick carries its table index in the address field.
    always_comb begin
        o_item.is_tick = is_tick;
        o_item.addr    = is_tick ? read_pos[iwo_pkg::PHASE_W-1:iwo_pkg::FRAC_BITS]
                                 : i_table_addr;
        o_item.value   = i_table_value;
        o_item.frac    = read_pos[iwo_pkg::FRAC_BITS-1:0];
        o_item.amp     = i_amplitude;
    end

    // Phase accumulator wraps modulo the table length in fixed point.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (accept && is_tick) begin
            r_phase <= r_phase + i_phase_step[iwo_pkg::PHASE_W-1:0];
        end
    end

endmodule

// File: rtl/iwo_back.sv
// Back part: pops items, writes loads into the wave table and runs ticks
// through four table reads, a shared multiplier and, in cubic mode, the rounding divider.
// Depends on iwo_pkg and iwo_ram.
module iwo_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_q_valid,
    input  iwo_pkg::t_item                        i_q_item,
    output logic                                  o_q_pop,
    input  logic [iwo_pkg::MODE_W-1:0]            i_mode,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [iwo_pkg::SAMPLE_BITS-1:0] o_sample,
    output logic                                  o_saturated
);

    localparam int VW = iwo_pkg::VAL_W;
    localparam int FB = iwo_pkg::FRAC_BITS;
    localparam int AW = iwo_pkg::ADDR_W;
    localparam int SB = iwo_pkg::SAMPLE_BITS;
    localparam int CW = VW + 5;            // coefficient working width
    localparam int TW = VW + 7;            // Horner partial result width
    localparam int WW = VW + FB + 9;       // interpolated value width
    localparam int LW = 24;                // low slice of the value for the gain product
    localparam int HW = WW - LW;           // high slice width
    localparam int MA = LW + 1;            // multiplier operand A width
    localparam int MB = FB + 1;            // multiplier operand B width
    localparam int MP = MA + MB;           // multiplier product width
    localparam int XW = WW + iwo_pkg::AMP_W;  // full gain product width
    localparam int DS = FB + 15;           // divisor shift for the Q1.15 result
    localparam int PW = XW - DS;           // pre-divide result width
    localparam int NW = SB + 2;            // halved cubic quotient operand width

    localparam logic signed [XW-1:0] BIAS_LIN   = XW'(1) <<< (DS - 1);
    localparam logic signed [XW-1:0] BIAS_CUBIC = XW'(3) <<< DS;
    localparam logic signed [PW-1:0] CUBIC_LIM  = PW'(6) <<< (SB - 1);
    localparam logic signed [PW-1:0] LIN_MAX    = PW'((1 << (SB - 1)) - 1);
    localparam logic signed [PW-1:0] LIN_MIN    = -PW'(1 << (SB - 1));
    localparam logic [NW-1:0]        RECIP3     = NW'(((1 << (NW + 1)) + 2) / 3);
    localparam logic signed [SB-1:0] SMAX       = SB'((1 << (SB - 1)) - 1);
    localparam logic signed [SB-1:0] SMIN       = SB'(1 << (SB - 1));

    iwo_pkg::t_back_state r_state, n_state;
    logic [1:0]           r_cnt, n_cnt;

    logic [AW-1:0]           r_idx;
    logic [FB-1:0]           r_frac;
    logic signed [VW-1:0]    r_amp;
    logic signed [VW-1:0]    r_y [4];
    logic signed [CW-3:0]    r_c3;
    logic signed [CW-2:0]    r_c2;
    logic signed [CW-2:0]    r_c1;
    logic signed [TW-1:0]    r_t;
    logic signed [WW-1:0]    r_w;
    logic signed [WW-1:0]    r_plo;
    logic signed [HW+VW-1:0] r_phi;
    logic signed [PW-1:0]    r_p;
    logic                    r_hi, r_lo;
    logic [NW-1:0]           r_n;
    logic signed [SB-1:0]    r_lin;

    logic                    r_out_vld;
    logic signed [SB-1:0]    r_sample;
    logic                    r_sat;

    logic                    ram_we, ram_re;
    logic [AW-1:0]           ram_raddr;
    logic [VW-1:0]           ram_rdata;

    logic                    cubic;
    logic signed [MB-1:0]    frac_eff;
    logic signed [MA-1:0]    mul_a;
    logic signed [MB-1:0]    mul_b;
    logic signed [MP-1:0]    mul_p;
    logic signed [CW-1:0]    y0e, y1e, y2e, y3e;
    logic signed [CW-1:0]    c3_full, c2_full, c1_full;
    logic signed [VW:0]      lin_diff;
    logic signed [WW-1:0]    y1_term;
    logic signed [XW-1:0]    gain_sum;
    logic signed [PW-1:0]    cubic_q;
    logic [2*NW-1:0]         div_prod;
    logic [SB-1:0]           div_quot;
    logic                    out_load;

    // Wave table memory
    iwo_ram #(
        .WIDTH (VW),
        .DEPTH (iwo_pkg::TABLE_LEN)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (i_q_item.addr),
        .i_wr_data (i_q_item.value),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iwo_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign out_load = (r_state == iwo_pkg::ST_FIN) && (!r_out_vld || !i_out_stall);

    // Sequencer: next state, queue pop and table port control
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        o_q_pop   = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_idx + AW'(r_cnt) - AW'(1);
        unique case (r_state)
            iwo_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.is_tick) begin
                        n_state = iwo_pkg::ST_READ;
                        n_cnt   = '0;
                    end else begin
                        ram_we = 1'b1;
                    end
                end
            end
            iwo_pkg::ST_READ: begin
                ram_re = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == 2'd3) begin
                    n_state = iwo_pkg::ST_LAST;
                end
            end
            iwo_pkg::ST_LAST: n_state = iwo_pkg::ST_COEF;
            iwo_pkg::ST_COEF: n_state = iwo_pkg::ST_M1;
            iwo_pkg::ST_M1:   n_state = iwo_pkg::ST_M2;
            iwo_pkg::ST_M2:   n_state = iwo_pkg::ST_M3;
            iwo_pkg::ST_M3:   n_state = iwo_pkg::ST_A1;
            iwo_pkg::ST_A1:   n_state = iwo_pkg::ST_A2;
            iwo_pkg::ST_A2:   n_state = iwo_pkg::ST_SUM;
            iwo_pkg::ST_SUM:  n_state = iwo_pkg::ST_DIV;
            iwo_pkg::ST_DIV:  n_state = iwo_pkg::ST_FIN;
            iwo_pkg::ST_FIN: begin
                if (out_load) begin
                    n_state = iwo_pkg::ST_IDLE;
                end
            end
            default: n_state = iwo_pkg::ST_IDLE;
        endcase
    end

    // Mode decode; truncation uses the linear path with a zero fraction.
    assign cubic    = (i_mode != iwo_pkg::MODE_TRUNC) && (i_mode != iwo_pkg::MODE_LINEAR);
    assign frac_eff = (i_mode == iwo_pkg::MODE_TRUNC) ? '0 : $signed({1'b0, r_frac});

    // Cubic coefficients from the four neighbors
    always_comb begin
        y0e      = CW'(r_y[0]);
        y1e      = CW'(r_y[1]);
        y2e      = CW'(r_y[2]);
        y3e      = CW'(r_y[3]);
        c3_full  = -y0e + CW'(3) * y1e - CW'(3) * y2e + y3e;
        c2_full  = CW'(3) * (y0e + y2e) - CW'(6) * y1e;
        c1_full  = CW'(6) * y2e - CW'(2) * y0e - CW'(3) * y1e - y3e;
        lin_diff = (VW+1)'(r_y[2]) - (VW+1)'(r_y[1]);
        y1_term  = cubic ? ((WW'(r_y[1]) * WW'(6)) <<< FB) : (WW'(r_y[1]) <<< FB);
    end

    // Shared multiplier: Horner steps against the fraction, then the gain
    always_comb begin
        mul_a = '0;
        mul_b = frac_eff;
        case (r_state)
            iwo_pkg::ST_M1: mul_a = MA'(r_c3);
            iwo_pkg::ST_M2: mul_a = MA'(r_t);
            iwo_pkg::ST_M3: mul_a = cubic ? MA'(r_t) : MA'(lin_diff);
            iwo_pkg::ST_A1: begin
                mul_a = $signed({1'b0, r_w[LW-1:0]});
                mul_b = MB'(r_amp);
            end
            iwo_pkg::ST_A2: begin
                mul_a = MA'($signed(r_w[WW-1:LW]));
                mul_b = MB'(r_amp);
            end
            default: mul_a = '0;
        endcase
        mul_p = MP'(mul_a) * MP'(mul_b);
    end

    // Recombined gain product with the rounding bias, and the cubic divide by six
    always_comb begin
        gain_sum = (XW'(r_phi) <<< LW) + XW'(r_plo) + (cubic ? BIAS_CUBIC : BIAS_LIN);
        cubic_q  = r_p + CUBIC_LIM;
        div_prod = (2*NW)'(r_n) * (2*NW)'(RECIP3);
        div_quot = div_prod[NW+1 +: SB];
    end

    // Datapath registers, advanced by the sequencer state
    always_ff @(posedge i_clk) begin
        case (r_state)
            iwo_pkg::ST_IDLE: begin
                r_idx  <= i_q_item.addr;
                r_frac <= i_q_item.frac;
                r_amp  <= i_q_item.amp;
            end
            iwo_pkg::ST_READ: begin
                if (r_cnt != 2'd0) begin
                    r_y[r_cnt - 2'd1] <= $signed(ram_rdata);
                end
            end
            iwo_pkg::ST_LAST: r_y[3] <= $signed(ram_rdata);
            iwo_pkg::ST_COEF: begin
                r_c3 <= (CW-2)'(c3_full);
                r_c2 <= (CW-1)'(c2_full);
                r_c1 <= (CW-1)'(c1_full);
            end
            iwo_pkg::ST_M1: r_t <= $signed(mul_p[FB +: TW]) + TW'(r_c2);
            iwo_pkg::ST_M2: r_t <= $signed(mul_p[FB +: TW]) + TW'(r_c1);
            iwo_pkg::ST_M3: r_w <= $signed(mul_p[WW-1:0]) + y1_term;
            iwo_pkg::ST_A1: r_plo <= $signed(mul_p[WW-1:0]);
            iwo_pkg::ST_A2: r_phi <= $signed(mul_p[HW+VW-1:0]);
            iwo_pkg::ST_SUM: r_p <= $signed(gain_sum[XW-1:DS]);
            iwo_pkg::ST_DIV: begin
                if (cubic) begin
                    r_hi <= (r_p >= CUBIC_LIM);
                    r_lo <= (r_p < -CUBIC_LIM);
                end else begin
                    r_hi <= (r_p > LIN_MAX);
                    r_lo <= (r_p < LIN_MIN);
                end
                r_n   <= cubic_q[NW:1];
                r_lin <= r_p[SB-1:0];
            end
            default: r_t <= r_t;
        endcase
    end

    // Output register: holds a finished sample while the next item proceeds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_sat <= r_hi || r_lo;
            if (r_hi) begin
                r_sample <= SMAX;
            end else if (r_lo) begin
                r_sample <= SMIN;
            end else if (cubic) begin
                // Quotient is offset by half the range; flipping the top bit removes it.
                r_sample <= $signed({~div_quot[SB-1], div_quot[SB-2:0]});
            end else begin
                r_sample <= r_lin;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_sample    = r_sample;
    assign o_saturated = r_sat;

endmodule

// File: rtl/interpolating_wavetable_oscillator_top.sv
// Interpolating wavetable oscillator, top level: configuration registers and
// the front part, queue and back part. Depends on iwo_pkg and all iwo_ modules.
// Throughput: one load beat per cycle while the queue has room; the back sequencer
// starts a tick only when done with the last item, with four table reads and one multiplier.
// Reset: phase zero, mode cubic, offset zero; table contents stay undefined.
module interpolating_wavetable_oscillator_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_op,
    input  logic [iwo_pkg::ADDR_W-1:0]            i_table_addr,
    input  logic signed [iwo_pkg::VAL_W-1:0]      i_table_value,
    input  logic signed [iwo_pkg::STEP_W-1:0]     i_phase_step,
    input  logic signed [iwo_pkg::AMP_W-1:0]      i_amplitude,
    // Output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [iwo_pkg::SAMPLE_BITS-1:0] o_sample,
    output logic                                  o_saturated,
    // Configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    logic [iwo_pkg::MODE_W-1:0] r_interp_mode;
    logic [iwo_pkg::ADDR_W-1:0] r_phase_offset;
    logic                       cfg_wr;
    logic                       cfg_sel;

    logic                       q_push, q_full, q_pop, q_valid;
    iwo_pkg::t_item             q_in_item, q_out_item;

    // Register write decode; the word index sits above the byte offset.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interp_mode  <= iwo_pkg::MODE_CUBIC;
            r_phase_offset <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                iwo_pkg::REG_INTERP_MODE:  r_interp_mode  <= pwdata[iwo_pkg::MODE_W-1:0];
                iwo_pkg::REG_PHASE_OFFSET: r_phase_offset <= pwdata[iwo_pkg::ADDR_W-1:0];
                default:                   r_interp_mode  <= r_interp_mode;
            endcase
        end
    end

    // Register read mux
    always_comb begin
        unique case (cfg_sel)
            iwo_pkg::REG_INTERP_MODE:  prdata = 32'(r_interp_mode);
            iwo_pkg::REG_PHASE_OFFSET: prdata = 32'(r_phase_offset);
            default:                   prdata = '0;
        endcase
    end

    // Front part: accepts and classifies beats, advances the phase
    iwo_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_table_addr   (i_table_addr),
        .i_table_value  (i_table_value),
        .i_phase_step   (i_phase_step),
        .i_amplitude    (i_amplitude),
        .i_phase_offset (r_phase_offset),
        .i_full         (q_full),
        .o_push         (q_push),
        .o_item         (q_in_item)
    );

    // Queue between the two parts
    iwo_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out_item)
    );

    // Back part: table writes, interpolation, gain and saturation
    iwo_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_out_item),
        .o_q_pop     (q_pop),
        .i_mode      (r_interp_mode),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample    (o_sample),
        .o_saturated (o_saturated)
    );

endmodule
